@@ rtl/sit_pkg.sv @@
// sit_pkg: types, widths and reset constants for the speed interval timer.
// Used by speed_interval_timer and its checker. No dependencies.
package sit_pkg;

  localparam int unsigned NumWin   = 3;
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned StampW   = 32;
  localparam int unsigned CfgIdxW  = 3;

  typedef logic [SpeedW-1:0] speed_t;
  typedef logic [StampW-1:0] stamp_t;

  // Interval value held before any window has completed (5 minutes in ms)
  localparam stamp_t IntervalReset = 32'd300000;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ZERO_FLOOR = 3'd0,
    CFG_START_A    = 3'd1,
    CFG_END_A      = 3'd2,
    CFG_START_B    = 3'd3,
    CFG_END_B      = 3'd4,
    CFG_START_C    = 3'd5,
    CFG_END_C      = 3'd6
  } cfg_reg_e;

  // Reset thresholds, 8.8 km/h
  localparam speed_t ZeroFloorReset = 16'd256;     // 1 km/h
  localparam speed_t StartAReset    = 16'd256;     // 1 km/h
  localparam speed_t EndAReset      = 16'd12800;   // 50 km/h
  localparam speed_t StartBReset    = 16'd256;     // 1 km/h
  localparam speed_t EndBReset      = 16'd25600;   // 100 km/h
  localparam speed_t StartCReset    = 16'd20480;   // 80 km/h
  localparam speed_t EndCReset      = 16'd30720;   // 120 km/h

  // Upward crossing: previous below the threshold, current at or above it
  function automatic logic crossed_up(speed_t prev, speed_t now, speed_t thr);
    return (now >= thr) && (prev < thr);
  endfunction

endpackage

@@ rtl/speed_interval_timer.sv @@
// speed_interval_timer: three start/end speed windows timing intervals in ms.
// Depends on sit_pkg.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+---------------------------
//  in      | in_valid_i, in_ready_o, stamp_ms_i,       | timestamped speed sample
//          | speed_i                                   |
//  out     | out_valid_o, out_ready_i, latest_*_o,     | window intervals after
//          | best_*_o, done_*_o                        | each sample
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,    | floor and threshold writes
//          | cfg_data_i                                |
//
// One item per cycle while results are taken; a result is offered once its item
// has passed the input register, then the window update into the result register.
// The window state and the result register load together, so the outputs read
// the window state directly. A stalled result holds the input register, which
// in turn drops in_ready_o. Reset restores all thresholds, zeroes the prior
// speed and start stamps and sets every interval to 300000 ms.
module speed_interval_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sit_pkg::StampW-1:0]    stamp_ms_i,
  input  logic [sit_pkg::SpeedW-1:0]    speed_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sit_pkg::StampW-1:0]    latest_a_o,
  output logic [sit_pkg::StampW-1:0]    best_a_o,
  output logic [sit_pkg::StampW-1:0]    latest_b_o,
  output logic [sit_pkg::StampW-1:0]    best_b_o,
  output logic [sit_pkg::StampW-1:0]    latest_c_o,
  output logic [sit_pkg::StampW-1:0]    best_c_o,
  output logic                          done_a_o,
  output logic                          done_b_o,
  output logic                          done_c_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sit_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sit_pkg::SpeedW-1:0]    cfg_data_i
);

  localparam int unsigned NumWin = sit_pkg::NumWin;

  // configuration
  sit_pkg::speed_t floor_q;
  sit_pkg::speed_t start_thr_q [NumWin];
  sit_pkg::speed_t end_thr_q   [NumWin];

  // input register
  logic            in_valid_q;
  sit_pkg::stamp_t stamp_q;
  sit_pkg::speed_t speed_q;

  // window state and result register
  sit_pkg::speed_t prior_q, prior_d;
  sit_pkg::stamp_t start_q  [NumWin];
  sit_pkg::stamp_t start_d  [NumWin];
  sit_pkg::stamp_t latest_q [NumWin];
  sit_pkg::stamp_t latest_d [NumWin];
  sit_pkg::stamp_t best_q   [NumWin];
  sit_pkg::stamp_t best_d   [NumWin];
  logic [NumWin-1:0] done_q, done_d;
  logic            out_valid_q;

  logic advance;

  // Pipeline control: update stage fires when an item waits and no result is held back
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q        <= sit_pkg::ZeroFloorReset;
      start_thr_q[0] <= sit_pkg::StartAReset;
      end_thr_q[0]   <= sit_pkg::EndAReset;
      start_thr_q[1] <= sit_pkg::StartBReset;
      end_thr_q[1]   <= sit_pkg::EndBReset;
      start_thr_q[2] <= sit_pkg::StartCReset;
      end_thr_q[2]   <= sit_pkg::EndCReset;
    end else if (cfg_valid_i) begin
      unique case (sit_pkg::cfg_reg_e'(cfg_index_i))
        sit_pkg::CFG_ZERO_FLOOR: floor_q        <= cfg_data_i;
        sit_pkg::CFG_START_A:    start_thr_q[0] <= cfg_data_i;
        sit_pkg::CFG_END_A:      end_thr_q[0]   <= cfg_data_i;
        sit_pkg::CFG_START_B:    start_thr_q[1] <= cfg_data_i;
        sit_pkg::CFG_END_B:      end_thr_q[1]   <= cfg_data_i;
        sit_pkg::CFG_START_C:    start_thr_q[2] <= cfg_data_i;
        sit_pkg::CFG_END_C:      end_thr_q[2]   <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stamp_q <= stamp_ms_i;
      speed_q <= speed_i;
    end
  end

  // Window update: clamp, crossings, interval, minimum
  always_comb begin
    sit_pkg::speed_t spd;
    sit_pkg::stamp_t iv;
    spd = (speed_q < floor_q) ? '0 : speed_q;
    prior_d = spd;
    iv = '0;
    for (int w = 0; w < NumWin; w++) begin
      start_d[w]  = start_q[w];
      latest_d[w] = latest_q[w];
      best_d[w]   = best_q[w];
      done_d[w]   = 1'b0;
      // start is checked first, so a same-sample end measures zero
      if (sit_pkg::crossed_up(prior_q, spd, start_thr_q[w])) begin
        start_d[w] = stamp_q;
      end
      if (sit_pkg::crossed_up(prior_q, spd, end_thr_q[w])) begin
        iv          = stamp_q - start_d[w];
        latest_d[w] = iv;
        if (iv < best_q[w]) begin
          best_d[w] = iv;
        end
        done_d[w] = 1'b1;
      end
    end
  end

  // Window state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prior_q     <= '0;
      done_q      <= '0;
      for (int w = 0; w < NumWin; w++) begin
        start_q[w]  <= '0;
        latest_q[w] <= sit_pkg::IntervalReset;
        best_q[w]   <= sit_pkg::IntervalReset;
      end
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        prior_q     <= prior_d;
        done_q      <= done_d;
        for (int w = 0; w < NumWin; w++) begin
          start_q[w]  <= start_d[w];
          latest_q[w] <= latest_d[w];
          best_q[w]   <= best_d[w];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Outputs
  assign out_valid_o = out_valid_q;
  assign latest_a_o  = latest_q[0];
  assign best_a_o    = best_q[0];
  assign latest_b_o  = latest_q[1];
  assign best_b_o    = best_q[1];
  assign latest_c_o  = latest_q[2];
  assign best_c_o    = best_q[2];
  assign done_a_o    = done_q[0];
  assign done_b_o    = done_q[1];
  assign done_c_o    = done_q[2];

endmodule

@@ rtl/sit_checker.sv @@
// sit_checker: port-level assertions for speed_interval_timer, bound to it below.
// Depends on sit_pkg and speed_interval_timer.
module sit_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [sit_pkg::StampW-1:0]  latest_a_o,
  input logic [sit_pkg::StampW-1:0]  best_a_o,
  input logic [sit_pkg::StampW-1:0]  best_b_o,
  input logic                        done_a_o
);

  // A held result keeps its values
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(latest_a_o) && $stable(best_a_o))
    else $error("result changed while stalled");

  // A completed window never leaves best above the fresh interval
  a_best_le_latest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_a_o |-> best_a_o <= latest_a_o)
    else $error("window A best above latest on completion");

  // Best interval only ever falls
  a_best_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_b_o <= $past(best_b_o))
    else $error("window B best grew");

  // Latest interval moves only with a completion flagged
  a_latest_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latest_a_o != $past(latest_a_o) |-> out_valid_o && done_a_o)
    else $error("window A latest changed without completion");

endmodule

bind speed_interval_timer sit_checker u_sit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .latest_a_o  (latest_a_o),
  .best_a_o    (best_a_o),
  .best_b_o    (best_b_o),
  .done_a_o    (done_a_o)
);

@@ verif/tb_speed_interval_timer.sv @@
`timescale 1ns / 100ps
// tb_speed_interval_timer: self-checking bench for the three-window speed interval timer.
// Depends on sit_pkg and speed_interval_timer; the expected window state is tracked in a class.

module tb_speed_interval_timer;

  localparam int NumWin      = sit_pkg::NumWin;
  localparam int NumRegs     = 7;
  localparam int QuietLimit  = 4000;  // cycles with no handshake before giving up
  localparam int HoldCycles  = 80;    // long receiver hold-off
  localparam int SettleCyc   = 4;     // pipeline is two deep
  localparam int PhaseItems  = 235;
  localparam int NumPhases   = 8;
  localparam int MaxShown    = 10;
  localparam logic [sit_pkg::CfgIdxW-1:0] RegIdxSpare = 3'd7;  // no register behind it

  // One expected or observed result item
  typedef struct packed {
    sit_pkg::stamp_t [NumWin-1:0] latest;
    sit_pkg::stamp_t [NumWin-1:0] best;
    logic            [NumWin-1:0] done;
  } window_report_t;

  // Tracks floor, thresholds and window state; queues the reports owed by the DUT
  class interval_tracker;
    sit_pkg::speed_t floor_thr;
    sit_pkg::speed_t start_thr [NumWin];
    sit_pkg::speed_t end_thr   [NumWin];
    sit_pkg::speed_t last_speed;
    sit_pkg::stamp_t win_start  [NumWin];
    sit_pkg::stamp_t win_latest [NumWin];
    sit_pkg::stamp_t win_best   [NumWin];
    window_report_t owed_reports [$];
    int unsigned mismatches;
    int unsigned reports_checked;
    int unsigned windows_closed;
    int unsigned samples_seen;

    function new();
      floor_thr    = sit_pkg::ZeroFloorReset;
      start_thr[0] = sit_pkg::StartAReset;
      end_thr[0]   = sit_pkg::EndAReset;
      start_thr[1] = sit_pkg::StartBReset;
      end_thr[1]   = sit_pkg::EndBReset;
      start_thr[2] = sit_pkg::StartCReset;
      end_thr[2]   = sit_pkg::EndCReset;
      last_speed   = '0;
      for (int w = 0; w < NumWin; w++) begin
        win_start[w]  = '0;
        win_latest[w] = sit_pkg::IntervalReset;
        win_best[w]   = sit_pkg::IntervalReset;
      end
    endfunction

    function void write_reg(logic [sit_pkg::CfgIdxW-1:0] idx, sit_pkg::speed_t val);
      case (idx)
        sit_pkg::CFG_ZERO_FLOOR: floor_thr    = val;
        sit_pkg::CFG_START_A:    start_thr[0] = val;
        sit_pkg::CFG_END_A:      end_thr[0]   = val;
        sit_pkg::CFG_START_B:    start_thr[1] = val;
        sit_pkg::CFG_END_B:      end_thr[1]   = val;
        sit_pkg::CFG_START_C:    start_thr[2] = val;
        sit_pkg::CFG_END_C:      end_thr[2]   = val;
        default: ;  // unmapped index, dropped
      endcase
    endfunction

    // Start is evaluated before end, so both in one sample gives interval 0
    function void take_sample(sit_pkg::stamp_t stamp, sit_pkg::speed_t spd);
      window_report_t rep;
      sit_pkg::speed_t now;
      now = (spd < floor_thr) ? '0 : spd;
      rep = '0;
      for (int w = 0; w < NumWin; w++) begin
        if (now >= start_thr[w] && last_speed < start_thr[w])
          win_start[w] = stamp;
        if (now >= end_thr[w] && last_speed < end_thr[w]) begin
          win_latest[w] = stamp - win_start[w];
          if (win_latest[w] < win_best[w])
            win_best[w] = win_latest[w];
          rep.done[w] = 1'b1;
          windows_closed++;
        end
        rep.latest[w] = win_latest[w];
        rep.best[w]   = win_best[w];
      end
      last_speed = now;
      samples_seen++;
      owed_reports.push_back(rep);
    endfunction

    function void log_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MaxShown)
        $display("[%0t] mismatch: %s expected %0h got %0h", $realtime, what, want, got);
    endfunction

    function void check_report(window_report_t got);
      window_report_t want;
      if (owed_reports.size() == 0) begin
        log_mismatch("result item with nothing outstanding", '0, 32'(got.done));
        return;
      end
      want = owed_reports.pop_front();
      reports_checked++;
      for (int w = 0; w < NumWin; w++) begin
        if (got.latest[w] !== want.latest[w])
          log_mismatch($sformatf("latest, window %0d", w), want.latest[w], got.latest[w]);
        if (got.best[w] !== want.best[w])
          log_mismatch($sformatf("best, window %0d", w), want.best[w], got.best[w]);
        if (got.done[w] !== want.done[w])
          log_mismatch($sformatf("done, window %0d", w), 32'(want.done[w]),
                       32'(got.done[w]));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sit_pkg::stamp_t stamp_ms_i = '0;
  sit_pkg::speed_t speed_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sit_pkg::stamp_t latest_a_o, best_a_o, latest_b_o, best_b_o, latest_c_o, best_c_o;
  logic done_a_o, done_b_o, done_c_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sit_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  sit_pkg::speed_t cfg_data_i = '0;

  interval_tracker timer_model = new();

  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int samples_sent = 0;
  int settings_loaded = 0;
  sit_pkg::stamp_t clock_ms = '0;
  sit_pkg::speed_t reg_plan [NumRegs];

  speed_interval_timer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stamp_ms_i (stamp_ms_i),
    .speed_i    (speed_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .latest_a_o (latest_a_o),
    .best_a_o   (best_a_o),
    .latest_b_o (latest_b_o),
    .best_b_o   (best_b_o),
    .latest_c_o (latest_c_o),
    .best_c_o   (best_c_o),
    .done_a_o   (done_a_o),
    .done_b_o   (done_b_o),
    .done_c_o   (done_c_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Handshake monitor: register writes, accepted samples, accepted results
  always @(posedge clk_i) begin : monitor
    window_report_t seen;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        timer_model.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o)
        timer_model.take_sample(stamp_ms_i, speed_i);
      if (out_valid_o && out_ready_i) begin
        seen.latest = {latest_c_o, latest_b_o, latest_a_o};
        seen.best   = {best_c_o, best_b_o, best_a_o};
        seen.done   = {done_c_o, done_b_o, done_a_o};
        timer_model.check_report(seen);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when asked for
  always @(posedge clk_i) begin : receiver
    if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no handshake at all
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", QuietLimit);
    $display("tb_speed_interval_timer: FAIL");
    $finish;
  end

  // Offer one sample, with random idle cycles first; returns on the accepting edge
  task automatic send_sample(sit_pkg::stamp_t stamp, sit_pkg::speed_t spd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stamp_ms_i <= stamp;
    speed_i    <= spd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    samples_sent++;
  endtask

  // Stop sending and wait for every owed result, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (timer_model.owed_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sit_pkg::CfgIdxW-1:0] idx, sit_pkg::speed_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Write the whole plan; optionally poke the unmapped index as well
  task automatic load_plan(bit poke_spare);
    for (int i = int'(sit_pkg::CFG_ZERO_FLOOR); i <= int'(sit_pkg::CFG_END_C); i++)
      write_reg(i[sit_pkg::CfgIdxW-1:0], reg_plan[i]);
    if (poke_spare)
      write_reg(RegIdxSpare, sit_pkg::speed_t'($urandom));
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  // 0: reset values, 1: ordered random thresholds, 2: anything goes
  task automatic pick_plan(int mode);
    case (mode)
      0: begin
        reg_plan[sit_pkg::CFG_ZERO_FLOOR] = sit_pkg::ZeroFloorReset;
        reg_plan[sit_pkg::CFG_START_A]    = sit_pkg::StartAReset;
        reg_plan[sit_pkg::CFG_END_A]      = sit_pkg::EndAReset;
        reg_plan[sit_pkg::CFG_START_B]    = sit_pkg::StartBReset;
        reg_plan[sit_pkg::CFG_END_B]      = sit_pkg::EndBReset;
        reg_plan[sit_pkg::CFG_START_C]    = sit_pkg::StartCReset;
        reg_plan[sit_pkg::CFG_END_C]      = sit_pkg::EndCReset;
      end
      1: begin
        reg_plan[sit_pkg::CFG_ZERO_FLOOR] = sit_pkg::speed_t'($urandom_range(1024));
        reg_plan[sit_pkg::CFG_START_A]    = sit_pkg::speed_t'($urandom_range(3000));
        reg_plan[sit_pkg::CFG_END_A]      =
          sit_pkg::speed_t'($urandom_range(40000, reg_plan[sit_pkg::CFG_START_A]));
        reg_plan[sit_pkg::CFG_START_B]    = sit_pkg::speed_t'($urandom_range(3000));
        reg_plan[sit_pkg::CFG_END_B]      =
          sit_pkg::speed_t'($urandom_range(60000, reg_plan[sit_pkg::CFG_START_B]));
        reg_plan[sit_pkg::CFG_START_C]    = sit_pkg::speed_t'($urandom_range(40000, 10000));
        reg_plan[sit_pkg::CFG_END_C]      =
          sit_pkg::speed_t'($urandom_range(65535, reg_plan[sit_pkg::CFG_START_C]));
      end
      default: begin
        for (int i = int'(sit_pkg::CFG_START_A); i <= int'(sit_pkg::CFG_END_C); i++)
          reg_plan[i] = sit_pkg::speed_t'($urandom);
        reg_plan[sit_pkg::CFG_ZERO_FLOOR] = sit_pkg::speed_t'($urandom_range(4000));
      end
    endcase
  endtask

  // Sender and receiver idling per phase
  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 45; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 45; end
      default: begin send_idle_pct = 20; stall_pct = 20; end
    endcase
  endtask

  // One acceleration run from rest (or a crawl) up to a random top speed and back
  task automatic drive_run();
    int v, top, step;
    if ($urandom_range(9) == 0)
      clock_ms = 32'hFFFF_FFFF - $urandom_range(20000);
    top = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(65535, 12000);
    v = ($urandom_range(3) == 0) ? $urandom_range(600) : 0;
    send_sample(clock_ms, sit_pkg::speed_t'(v));
    while (v < top) begin
      step = ($urandom_range(7) == 0) ? $urandom_range(30000, 1) : $urandom_range(3000, 1);
      v = (v + step > top) ? top : v + step;
      clock_ms += $urandom_range(1500);
      send_sample(clock_ms, sit_pkg::speed_t'(v));
    end
    // braking, with the odd dip that re-crosses thresholds on the next run
    while (v > 0) begin
      step = $urandom_range(20000, 1);
      v = (v - step < 0) ? 0 : v - step;
      clock_ms += $urandom_range(1500);
      send_sample(clock_ms, sit_pkg::speed_t'(v));
    end
  endtask

  // Main sequence
  initial begin : stimulus
    int phase_base;
    bit mid_done;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset thresholds: floor clamp, each window, wrap, start+end together
    send_sample(32'd0, 16'd0);
    send_sample(32'd100, 16'd255);
    send_sample(32'd1000, 16'd256);
    send_sample(32'd5000, 16'd12800);
    send_sample(32'd7000, 16'd20480);
    send_sample(32'd9000, 16'd25600);
    send_sample(32'd12000, 16'd30720);
    send_sample(32'd12500, 16'hFFFF);
    send_sample(32'd13000, 16'd0);
    send_sample(32'hFFFF_FF00, 16'd256);
    send_sample(32'h0000_0100, 16'hFFFF);
    send_sample(32'h0000_0200, 16'd0);
    send_sample(32'h0000_0300, 16'hFFFF);
    send_sample(32'hFFFF_FFFF, 16'd0);
    send_sample(32'd0, 16'd12800);
    drain();

    // All thresholds and floor at zero: no crossing can fire; spare index ignored
    foreach (reg_plan[i]) reg_plan[i] = '0;
    load_plan(1'b1);
    send_sample(32'd10, 16'd0);
    send_sample(32'd20, 16'hFFFF);
    send_sample(32'd30, 16'd1);
    drain();

    // All at full scale: only 0xFFFF survives the floor and closes every window
    foreach (reg_plan[i]) reg_plan[i] = 16'hFFFF;
    load_plan(1'b0);
    send_sample(32'd40, 16'hFFFE);
    send_sample(32'd50, 16'hFFFF);
    send_sample(32'd60, 16'd0);
    drain();

    // Window C end reached without its start being crossed
    pick_plan(0);
    reg_plan[sit_pkg::CFG_START_C] = 16'hFFFF;
    load_plan(1'b0);
    send_sample(32'd70, 16'd40000);
    send_sample(32'd80, 16'd0);
    drain();

    // Random phases
    for (int p = 0; p < NumPhases; p++) begin
      pick_plan(p % 3);
      load_plan(p == 0);
      set_idling(p % 4);
      phase_base = samples_sent;
      mid_done = 1'b0;
      while (samples_sent - phase_base < PhaseItems) begin
        if (!mid_done && samples_sent - phase_base >= PhaseItems / 2) begin
          mid_done = 1'b1;
          if (p % 2 == 0)
            holds_asked++;   // receiver holds off while samples keep coming
          else
            drain();         // sender pauses until everything is back
        end
        if ($urandom_range(4) != 0) begin
          drive_run();
        end else begin
          repeat ($urandom_range(5, 1))
            send_sample(sit_pkg::stamp_t'($urandom), sit_pkg::speed_t'($urandom));
        end
      end
      drain();
    end

    if (timer_model.owed_reports.size() != 0)
      timer_model.log_mismatch("result items never delivered",
                               32'(timer_model.owed_reports.size()), '0);
    $display("Covered %0d samples under %0d threshold settings; %0d windows closed.",
             samples_sent, settings_loaded, timer_model.windows_closed);
    $display("Compared %0d result items, %0d mismatches.",
             timer_model.reports_checked, timer_model.mismatches);
    if (timer_model.mismatches == 0)
      $display("tb_speed_interval_timer: PASS");
    else
      $display("tb_speed_interval_timer: FAIL");
    $finish;
  end

endmodule
